// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/lkw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lkw_pkg;
  localparam int OFF_W = 16;
  localparam int M_W = 16;
  localparam int A_W = 4;
  localparam int PH_W = 36;
  localparam int D_W = 36;
  localparam int F_W = 30;
  localparam int P_W = 34;
  localparam int S_W = 32;
  localparam int Q_W = 32;
  localparam int W_W = 16;
  localparam int HORNER_N = 6;
  localparam int PIPE_LAT = 81;
  localparam int CTL_DEPTH = 80;
  localparam int MDL_DEPTH = 36;
  localparam int D1_DEPTH = 45;
  localparam int D2_DEPTH = 9;
  localparam int NEG_DEPTH = 32;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [P_W-1:0] SC1 = 34'd5548789346;
  localparam logic [P_W-1:0] SC2 = 34'd2738217788;
  localparam logic [P_W-1:0] SC3 = 34'd643455389;
  localparam logic [P_W-1:0] SC4 = 34'd88203474;
  localparam logic [P_W-1:0] SC5 = 34'd7913940;
  localparam logic [P_W-1:0] SC6 = 34'd500689;
  localparam logic [P_W-1:0] HORNER_COEF [HORNER_N] =
    '{SC5, SC4, SC3, SC2, SC1, {2'b00, PI_Q30}};

  localparam logic [W_W-1:0] ONE_Q14 = 16'd16384;
  localparam logic [W_W-1:0] POS_MAX = 16'd32767;
  localparam logic [17:0] NEG_MAG_MAX = 18'd32768;
  localparam logic [17:0] POS_MAG_MAX = 18'd32767;
  localparam logic [A_W-1:0] LOBES_RST = 4'd3;

  typedef struct packed {
    logic vld;
    logic spec;
    logic one;
  } lkw_ctl_t;
endpackage
`default_nettype wire

// File: src/lkw_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lkw_div_cell #(
  parameter int RW = 4,
  parameter int QW = 36
) (
  input  logic          clk,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] dq_i,
  input  logic [RW-1:0] dsor_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] dq_o,
  output logic [RW-1:0] dsor_o
);
  logic [RW:0] trial;
  logic [RW:0] diff;
  logic ge;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] dq_r;
  logic [RW-1:0] dsor_r;

  always_comb begin
    trial = {rem_i, dq_i[QW-1]};
    diff = trial - {1'b0, dsor_i};
    ge = (trial >= {1'b0, dsor_i});
  end

  always_ff @(posedge clk) begin
    rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
    dq_r <= {dq_i[QW-2:0], ge};
    dsor_r <= dsor_i;
  end

  assign rem_o = rem_r;
  assign dq_o = dq_r;
  assign dsor_o = dsor_r;
endmodule
`default_nettype wire

// File: src/lkw_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module lkw_divider #(
  parameter int RW = 4,
  parameter int QW = 36
) (
  input  logic          clk,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] dend_i,
  input  logic [RW-1:0] dsor_i,
  output logic [QW-1:0] quo_o
);
  logic [RW-1:0] rem_c [QW+1];
  logic [QW-1:0] dq_c [QW+1];
  logic [RW-1:0] dsor_c [QW+1];

  assign rem_c[0] = rem_i;
  assign dq_c[0] = dend_i;
  assign dsor_c[0] = dsor_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lkw_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk   (clk),
      .rem_i (rem_c[i]),
      .dq_i  (dq_c[i]),
      .dsor_i(dsor_c[i]),
      .rem_o (rem_c[i+1]),
      .dq_o  (dq_c[i+1]),
      .dsor_o(dsor_c[i+1])
    );
  end

  assign quo_o = dq_c[QW];
endmodule
`default_nettype wire

// File: src/lkw_horner_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lkw_horner_cell import lkw_pkg::*; #(
  parameter logic [P_W-1:0] COEF = SC1
) (
  input  logic           clk,
  input  logic [P_W-1:0] p_i,
  input  logic [F_W-1:0] z_i,
  input  logic [F_W-1:0] f_i,
  input  logic           neg_i,
  output logic [P_W-1:0] p_o,
  output logic [F_W-1:0] z_o,
  output logic [F_W-1:0] f_o,
  output logic           neg_o
);
  logic [P_W+F_W-1:0] prod;
  logic [P_W-1:0] p_r;
  logic [F_W-1:0] z_r;
  logic [F_W-1:0] f_r;
  logic neg_r;

  assign prod = p_i * z_i;

  always_ff @(posedge clk) begin
    p_r <= COEF - prod[P_W+F_W-1:F_W];
    z_r <= z_i;
    f_r <= f_i;
    neg_r <= neg_i;
  end

  assign p_o = p_r;
  assign z_o = z_r;
  assign f_o = f_r;
  assign neg_o = neg_r;
endmodule
`default_nettype wire

// File: src/lkw_sin_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module lkw_sin_pipe import lkw_pkg::*; (
  input  logic            clk,
  input  logic [PH_W-1:0] phase_i,
  output logic [S_W-1:0]  s_o,
  output logic            neg_o
);
  logic [31:0] frac;
  logic [32:0] fold;
  logic [F_W-1:0] f1_r;
  logic n1_r;
  logic [2*F_W-1:0] sq;
  logic [F_W-1:0] z2_r;
  logic [F_W-1:0] f2_r;
  logic n2_r;
  logic [P_W-1:0] hp [HORNER_N+1];
  logic [F_W-1:0] hz [HORNER_N+1];
  logic [F_W-1:0] hf [HORNER_N+1];
  logic hn [HORNER_N+1];
  logic [P_W+F_W-1:0] fin;
  logic [S_W-1:0] s_r;
  logic neg_r;

  always_comb begin
    frac = phase_i[31:0];
    if (frac > 32'h8000_0000) begin
      fold = 33'h1_0000_0000 - {1'b0, frac};
    end else begin
      fold = {1'b0, frac};
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= fold[31:2];
    n1_r <= phase_i[32];
  end

  assign sq = f1_r * f1_r;

  always_ff @(posedge clk) begin
    z2_r <= sq[2*F_W-1:F_W];
    f2_r <= f1_r;
    n2_r <= n1_r;
  end

  assign hp[0] = SC6;
  assign hz[0] = z2_r;
  assign hf[0] = f2_r;
  assign hn[0] = n2_r;

  for (genvar i = 0; i < HORNER_N; i++) begin : g_horner
    lkw_horner_cell #(.COEF(HORNER_COEF[i])) u_cell (
      .clk  (clk),
      .p_i  (hp[i]),
      .z_i  (hz[i]),
      .f_i  (hf[i]),
      .neg_i(hn[i]),
      .p_o  (hp[i+1]),
      .z_o  (hz[i+1]),
      .f_o  (hf[i+1]),
      .neg_o(hn[i+1])
    );
  end

  assign fin = hp[HORNER_N] * hf[HORNER_N];

  always_ff @(posedge clk) begin
    s_r <= fin[F_W+S_W-1:F_W];
    neg_r <= hn[HORNER_N];
  end

  assign s_o = s_r;
  assign neg_o = neg_r;
endmodule
`default_nettype wire

// File: src/lanczos_kernel_weight_core.sv
// Channel   Handshake            Payload
// input     start / busy         in_offset   (signed Q4.12)
// result    out_strobe           out_weight  (signed Q2.14)
// config    cfg_we               cfg_lobes   (4 bit, reset 3)
//
// One transaction is taken every cycle while busy is low; results keep their order.
// The pipeline holds the 36-cell divider by the lobe count, the 9-stage sine
// pipeline and the 32-cell divider of each sine by its denominator.
// Reset is synchronous; busy is high only during reset and the cycle after it.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lanczos_kernel_weight_core import lkw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [OFF_W-1:0] in_offset,
  output logic                    out_strobe,
  output logic signed [W_W-1:0]   out_weight,
  input  logic                    cfg_we,
  input  logic [A_W-1:0]          cfg_lobes
);
  logic [A_W-1:0] lobes_r;
  logic busy_r;
  logic [M_W-1:0] m_nxt;
  logic is_zero;
  logic beyond;
  lkw_ctl_t ctl_nxt;
  lkw_ctl_t ctl_r [CTL_DEPTH];
  logic [M_W-1:0] m1_r;
  logic [A_W-1:0] a1_r;
  logic [M_W+31:0] pim;
  logic [D_W-1:0] d1b_r;
  logic [M_W-1:0] m2_r;
  logic [A_W-1:0] a2_r;
  logic [M_W-1:0] mdl_r [MDL_DEPTH];
  logic [D_W-1:0] d1dl_r [D1_DEPTH];
  logic [D_W-1:0] d2dl_r [D2_DEPTH];
  logic [PH_W-1:0] p2q;
  logic [D_W-1:0] d2q;
  logic [S_W-1:0] s1;
  logic [S_W-1:0] s2;
  logic n1;
  logic n2;
  logic ndl_r [NEG_DEPTH];
  logic [Q_W-1:0] r1;
  logic [Q_W-1:0] r2;
  logic [2*Q_W-1:0] prod_r;
  logic neg_r;
  logic [2*Q_W-1:0] rsum;
  logic [17:0] mag;
  logic [W_W-1:0] calc;
  logic strobe_r;
  logic [W_W-1:0] weight_r;
  logic [W_W-1:0] weight_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lobes_r <= LOBES_RST;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        lobes_r <= cfg_lobes;
      end
    end
  end

  always_comb begin
    m_nxt = in_offset[OFF_W-1] ? (16'd0 - $unsigned(in_offset)) : $unsigned(in_offset);
    is_zero = (m_nxt == '0);
    beyond = (m_nxt > {lobes_r, 12'd0});
    ctl_nxt.vld = start && !busy_r;
    ctl_nxt.spec = is_zero || beyond;
    ctl_nxt.one = is_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTL_DEPTH; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i < CTL_DEPTH; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign pim = PI_Q30 * m1_r;

  always_ff @(posedge clk) begin
    m1_r <= m_nxt;
    a1_r <= lobes_r;
    d1b_r <= pim[M_W+31:12];
    m2_r <= m1_r;
    a2_r <= a1_r;
    mdl_r[0] <= m2_r;
    for (int i = 1; i < MDL_DEPTH; i++) begin
      mdl_r[i] <= mdl_r[i-1];
    end
    d1dl_r[0] <= d1b_r;
    for (int i = 1; i < D1_DEPTH; i++) begin
      d1dl_r[i] <= d1dl_r[i-1];
    end
    d2dl_r[0] <= d2q;
    for (int i = 1; i < D2_DEPTH; i++) begin
      d2dl_r[i] <= d2dl_r[i-1];
    end
    ndl_r[0] <= n1 ^ n2;
    for (int i = 1; i < NEG_DEPTH; i++) begin
      ndl_r[i] <= ndl_r[i-1];
    end
  end

  lkw_divider #(.RW(A_W), .QW(PH_W)) u_div_phase (
    .clk   (clk),
    .rem_i ('0),
    .dend_i({m2_r, 20'd0}),
    .dsor_i(a2_r),
    .quo_o (p2q)
  );

  lkw_divider #(.RW(A_W), .QW(D_W)) u_div_den (
    .clk   (clk),
    .rem_i ('0),
    .dend_i(d1b_r),
    .dsor_i(a2_r),
    .quo_o (d2q)
  );

  lkw_sin_pipe u_sin1 (
    .clk    (clk),
    .phase_i({mdl_r[MDL_DEPTH-1], 20'd0}),
    .s_o    (s1),
    .neg_o  (n1)
  );

  lkw_sin_pipe u_sin2 (
    .clk    (clk),
    .phase_i(p2q),
    .s_o    (s2),
    .neg_o  (n2)
  );

  lkw_divider #(.RW(D_W), .QW(Q_W)) u_div_r1 (
    .clk   (clk),
    .rem_i ({6'd0, s1[S_W-1:2]}),
    .dend_i({s1[1:0], 30'd0}),
    .dsor_i(d1dl_r[D1_DEPTH-1]),
    .quo_o (r1)
  );

  lkw_divider #(.RW(D_W), .QW(Q_W)) u_div_r2 (
    .clk   (clk),
    .rem_i ({6'd0, s2[S_W-1:2]}),
    .dend_i({s2[1:0], 30'd0}),
    .dsor_i(d2dl_r[D2_DEPTH-1]),
    .quo_o (r2)
  );

  always_ff @(posedge clk) begin
    prod_r <= r1 * r2;
    neg_r <= ndl_r[NEG_DEPTH-1];
  end

  always_comb begin
    rsum = prod_r + 64'h0000_2000_0000_0000;
    mag = rsum[63:46];
    if (neg_r) begin
      calc = (mag > NEG_MAG_MAX) ? 16'h8000 : (16'd0 - mag[15:0]);
    end else begin
      calc = (mag > POS_MAG_MAX) ? POS_MAX : mag[15:0];
    end
    if (ctl_r[CTL_DEPTH-1].spec) begin
      weight_nxt = ctl_r[CTL_DEPTH-1].one ? ONE_Q14 : '0;
    end else begin
      weight_nxt = calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_r[CTL_DEPTH-1].vld;
    end
    weight_r <= weight_nxt;
  end

  assign busy = busy_r;
  assign out_strobe = strobe_r;
  assign out_weight = $signed(weight_r);

  `ASSERT_IMPL(a_latency, clk, rst_n, start && !busy, ##PIPE_LAT out_strobe)
  `ASSERT_IMPL(a_no_spurious, clk, rst_n, out_strobe, $past(start && !busy, PIPE_LAT))
  `ASSERT_IMPL(a_zero_is_one, clk, rst_n, out_strobe && $past(start && !busy && (in_offset == '0), PIPE_LAT), out_weight == $signed(ONE_Q14))
  `ASSERT_NEXT(a_busy_after_reset, clk, rst_n, busy, !busy)
endmodule
`default_nettype wire

// File: bench/lanczos_kernel_weight_core_tb.sv
`timescale 1ns / 1ps
module lanczos_kernel_weight_core_tb;
  import lkw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PIPE_WAIT = PIPE_LAT + 20;
  localparam logic [63:0] PI_Q30_64 = 64'd3373259426;
  localparam logic [63:0] HALF_LSB_Q46 = 64'd1 << 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [OFF_W-1:0] in_offset = '0;
  logic out_strobe;
  logic signed [W_W-1:0] out_weight;
  logic cfg_we = 1'b0;
  logic [A_W-1:0] cfg_lobes = '0;

  logic [A_W-1:0] lobe_count;
  int idle_cycles = 0;
  bit done = 1'b0;

  lanczos_kernel_weight_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_offset(in_offset),
    .out_strobe(out_strobe), .out_weight(out_weight), .cfg_we(cfg_we),
    .cfg_lobes(cfg_lobes)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] sine_mag_q30(input logic [63:0] phase, output bit neg);
    logic [63:0] frac, f30, z, p;
    neg = phase[32];
    frac = phase & 64'hFFFF_FFFF;
    if (frac > 64'h8000_0000) frac = 64'h1_0000_0000 - frac;
    f30 = frac >> 2;
    z = (f30 * f30) >> 30;
    p = 64'(SC6);
    p = 64'(SC5) - ((p * z) >> 30);
    p = 64'(SC4) - ((p * z) >> 30);
    p = 64'(SC3) - ((p * z) >> 30);
    p = 64'(SC2) - ((p * z) >> 30);
    p = 64'(SC1) - ((p * z) >> 30);
    p = PI_Q30_64 - ((p * z) >> 30);
    return (p * f30) >> 30;
  endfunction

  function automatic logic [15:0] lanczos_weight(input logic [15:0] raw,
                                                 input logic [A_W-1:0] lobes);
    logic [63:0] m, a, s1, s2, d1, d2, r1, r2, mag;
    bit n1, n2;
    a = 64'(lobes);
    m = raw[15] ? (64'h1_0000 - 64'(raw)) : 64'(raw);
    if (m == 0) return ONE_Q14;
    if (m > a * 4096) return 16'd0;
    s1 = sine_mag_q30(m << 20, n1);
    s2 = sine_mag_q30((m << 20) / a, n2);
    d1 = (PI_Q30_64 * m) >> 12;
    d2 = (PI_Q30_64 * m) / (a * 4096);
    r1 = (s1 << 30) / d1;
    r2 = (s2 << 30) / d2;
    mag = (r1 * r2 + HALF_LSB_Q46) >> 46;
    if (n1 != n2) begin
      if (mag > 32768) mag = 32768;
      return 16'(64'd0 - mag);
    end
    if (mag > 32767) mag = 32767;
    return 16'(mag);
  endfunction

  class weight_scoreboard;
    logic [15:0] pending_weights[$];
    int mismatches = 0;

    function void note_offset(logic [15:0] offset, logic [A_W-1:0] lobes);
      pending_weights.push_back(lanczos_weight(offset, lobes));
    endfunction

    function void check_weight(logic [15:0] actual);
      logic [15:0] expected;
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected weight %0d", $signed(actual));
        return;
      end
      expected = pending_weights.pop_front();
      if (actual !== expected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Weight mismatch: expected %0d, actual %0d",
                   $signed(expected), $signed(actual));
      end
    endfunction
  endclass

  weight_scoreboard board = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_offset(in_offset, lobe_count);
      if (out_strobe) board.check_weight(out_weight);
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!done && idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lanczos_kernel_weight_core test failed");
        $finish;
      end
    end
  end

  task automatic send_offset(input logic [15:0] value);
    start <= 1'b1;
    in_offset <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    in_offset <= 16'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic set_lobes(input logic [A_W-1:0] value);
    start <= 1'b0;
    while (board.pending_weights.size() != 0) @(negedge clk);
    repeat (PIPE_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_lobes <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    lobe_count = value;
  endtask

  function automatic logic [15:0] random_offset(input logic [A_W-1:0] lobes);
    int pick;
    int radius;
    pick = $urandom_range(0, 9);
    radius = int'(lobes) * 4096;
    if (radius > 32768) radius = 32768;
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return 16'($urandom_range(0, 3)) ^ {16{$urandom_range(0, 1) == 1}};
    if (pick == 2) return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 8)) * 4096);
    if (radius == 0) return 16'($urandom);
    return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, radius)));
  endfunction

  initial begin
    logic [15:0] directed[$];
    logic [A_W-1:0] lobe_plan[$];
    int burst;
    lobe_count = LOBES_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h1000,
                 16'hF000, 16'h3000, 16'hD000, 16'h3001, 16'hCFFF, 16'h0800, 16'hF800,
                 16'h1800, 16'h2AAA, 16'h5555, 16'hAAAA, 16'h2FFF, 16'h0002};
    foreach (directed[i]) send_offset(directed[i]);
    lobe_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3};
    foreach (lobe_plan[p]) begin
      set_lobes(lobe_plan[p]);
      send_offset(16'h0000);
      send_offset(16'(int'(lobe_plan[p]) * 4096));
      send_offset(16'h8000);
      for (int n = 0; n < 70; ) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && n < 70; k++, n++) send_offset(random_offset(lobe_count));
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 7));
      end
    end
    start <= 1'b0;
    while (board.pending_weights.size() != 0) @(negedge clk);
    repeat (PIPE_WAIT) @(negedge clk);
    done = 1'b1;
    if (board.mismatches == 0) begin
      $display("lanczos_kernel_weight_core test passed");
    end else begin
      $display("lanczos_kernel_weight_core test failed");
    end
    $finish;
  end
endmodule
